>>> hw/rtl/acc_pkg.sv
package acc_pkg;

    localparam int NUM_ALARMS_DEF = 3;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_VIEW_PERIOD = 1'b0;
    localparam logic [7:0] VIEW_PERIOD_RST = 8'd25;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_MODE  = 3'd1;
    localparam logic [2:0] CMD_ADD   = 3'd2;
    localparam logic [2:0] CMD_MINUS = 3'd3;
    localparam logic [2:0] CMD_OK    = 3'd4;

    localparam int MODE_VIEW = 0;
    localparam int MODE_HOUR = 1;
    localparam int MODE_MIN  = 2;
    localparam int MODE_SEC  = 3;
    localparam int MODE_ALM0 = 4;

    localparam logic [1:0] FLD_HOUR = 2'd0;
    localparam logic [1:0] FLD_MIN  = 2'd1;
    localparam logic [1:0] FLD_EN   = 2'd2;

    localparam logic [6:0] HOUR_LIM = 7'd24;
    localparam logic [6:0] MIN_LIM  = 7'd60;

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] rtc_hour;
        logic [5:0] rtc_minute;
        logic [5:0] rtc_second;
    } t_in_word;

    typedef struct packed {
        logic [4:0] cur_hour;
        logic [5:0] cur_minute;
        logic [5:0] cur_second;
        logic [3:0] edit_state;
        logic       alarm_active;
        logic       rtc_store;
        logic [1:0] shown_alarm;
        logic [4:0] shown_alarm_hour;
        logic [5:0] shown_alarm_minute;
        logic       shown_alarm_on;
    } t_out_word;

    typedef struct packed {
        logic       adj;
        logic       up;
        logic [1:0] fld;
    } t_alm_edit;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       on;
    } t_alm_view;

    // step up or down modulo lim; held value may be out of range, so subtract either lim or twice lim
    function automatic logic [5:0] wrap_step(logic [5:0] v, logic [6:0] lim, logic up);
        logic [7:0] x;
        x = up ? ({2'b00, v} + 8'd1) : ({2'b00, v} + {1'b0, lim} - 8'd1);
        if (x >= {lim, 1'b0}) begin
            x = x - {lim, 1'b0};
        end else if (x >= {1'b0, lim}) begin
            x = x - {1'b0, lim};
        end
        return x[5:0];
    endfunction

    function automatic logic [4:0] alarm_hour_init(int i);
        logic [4:0] h;
        case (i)
            0: h = 5'd7;
            1: h = 5'd12;
            2: h = 5'd18;
            default: h = 5'd0;
        endcase
        return h;
    endfunction

endpackage

>>> hw/rtl/alarm_clock_controller_top.sv
// Channel   Direction  Valid        Stall        Word
// input     in         i_in_valid   o_in_stall   i_in_word  (t_in_word)
// output    out        o_out_valid  i_out_stall  o_out_word (t_out_word)
// config    in         psel/penable pready (=1)  paddr, pwdata, prdata
//
// One word per cycle unless the output stalls; a word moves on once the output register is free or being emptied.
// The whole pass is one combinational step from the input register to the output register.
// Reset is synchronous, active low; there is no clearing pass.
// An output stall holds the output register; the input register still takes a word
// while it is empty or the output register is free or being emptied.
module alarm_clock_controller_top
    import acc_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_word           i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_word          o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic       r_view_period;
    logic [7:0] r_period;
    logic       r_in_vld;
    t_in_word   r_in;
    logic       r_out_vld;
    t_out_word  r_out;
    t_out_word  res;
    logic       adv;
    logic       step;
    logic       reg_sel;

    assign reg_sel = (paddr[PADDR_W-1] == REG_VIEW_PERIOD);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(PDATA_W-8){1'b0}}, r_period} : '0;

    // r_view_period marks that the register has been written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= VIEW_PERIOD_RST;
            r_view_period <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_period      <= pwdata[7:0];
            r_view_period <= 1'b1;
        end
    end

    assign adv        = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && adv;
    assign o_in_stall = r_in_vld && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    acc_core #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_word        (r_in),
        .i_view_period (r_period),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    a_period_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_view_period |-> (r_period == VIEW_PERIOD_RST))
        else $error("view period changed without a write");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled output word lost or changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> (r_in_vld && $stable(r_in)))
        else $error("input word lost while stalled");

endmodule

>>> hw/rtl/acc_alarm_bank.sv
module acc_alarm_bank
    import acc_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_DEF,
    parameter int IDX_W      = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_alm_edit        i_edit,
    input  logic [IDX_W-1:0] i_sel,
    input  logic [4:0]       i_hour,
    input  logic [5:0]       i_minute,
    input  logic [IDX_W-1:0] i_show,
    output logic             o_hit,
    output t_alm_view        o_view
);

    logic [4:0] r_hour [NUM_ALARMS];
    logic [5:0] r_min  [NUM_ALARMS];
    logic       r_en   [NUM_ALARMS];
    logic [4:0] n_hour [NUM_ALARMS];
    logic [5:0] n_min  [NUM_ALARMS];
    logic       n_en   [NUM_ALARMS];

    always_comb begin
        o_hit = 1'b0;
        for (int i = 0; i < NUM_ALARMS; i++) begin
            n_hour[i] = r_hour[i];
            n_min[i]  = r_min[i];
            n_en[i]   = r_en[i];
            if (i_edit.adj && (i_sel == IDX_W'(i))) begin
                case (i_edit.fld)
                    FLD_HOUR: n_hour[i] = 5'(wrap_step({1'b0, r_hour[i]}, HOUR_LIM, i_edit.up));
                    FLD_MIN:  n_min[i]  = wrap_step(r_min[i], MIN_LIM, i_edit.up);
                    FLD_EN:   n_en[i]   = ~r_en[i];
                    default:  ;
                endcase
            end
            if (n_en[i] && (n_hour[i] == i_hour) && (n_min[i] == i_minute)) begin
                o_hit = 1'b1;
            end
        end
    end

    always_comb begin
        o_view.hour   = n_hour[i_show];
        o_view.minute = n_min[i_show];
        o_view.on     = n_en[i_show];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ALARMS; i++) begin
                r_hour[i] <= alarm_hour_init(i);
                r_min[i]  <= 6'd0;
                r_en[i]   <= (i == 0);
            end
        end else if (i_step) begin
            for (int i = 0; i < NUM_ALARMS; i++) begin
                r_hour[i] <= n_hour[i];
                r_min[i]  <= n_min[i];
                r_en[i]   <= n_en[i];
            end
        end
    end

endmodule

>>> hw/rtl/acc_core.sv
module acc_core
    import acc_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_word   i_word,
    input  logic [7:0] i_view_period,
    output t_out_word  o_res
);

    localparam int IDX_W  = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int MODE_W = $clog2(3 * NUM_ALARMS + 4);
    localparam logic [MODE_W-1:0] M_VIEW = MODE_W'(MODE_VIEW);
    localparam logic [MODE_W-1:0] M_HOUR = MODE_W'(MODE_HOUR);
    localparam logic [MODE_W-1:0] M_MIN  = MODE_W'(MODE_MIN);
    localparam logic [MODE_W-1:0] M_SEC  = MODE_W'(MODE_SEC);
    localparam logic [MODE_W-1:0] M_ALM0 = MODE_W'(MODE_ALM0);
    localparam logic [MODE_W-1:0] M_LAST = MODE_W'(3 * NUM_ALARMS + 3);
    localparam logic [IDX_W:0]    N_ALM  = (IDX_W + 1)'(NUM_ALARMS);

    logic [4:0]        r_hour, n_hour;
    logic [5:0]        r_min, n_min;
    logic [5:0]        r_sec, n_sec;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [IDX_W-1:0]  r_sel, n_sel;
    logic [1:0]        r_fld, n_fld;
    logic              r_ring, n_ring;
    logic              r_lm_vld, n_lm_vld;
    logic [4:0]        r_lm_hour, n_lm_hour;
    logic [5:0]        r_lm_min, n_lm_min;
    logic [IDX_W-1:0]  r_view_idx, n_view_idx;
    logic [7:0]        r_view_cnt, n_view_cnt;

    logic             load;
    logic             store;
    logic             up;
    logic             hit;
    logic             ring_kept;
    logic [IDX_W:0]   idx_inc;
    logic [IDX_W-1:0] shown;
    t_alm_edit        edit;
    t_alm_view        view;

    acc_alarm_bank #(
        .NUM_ALARMS (NUM_ALARMS),
        .IDX_W      (IDX_W)
    ) u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (i_step),
        .i_edit   (edit),
        .i_sel    (r_sel),
        .i_hour   (n_hour),
        .i_minute (n_min),
        .i_show   (shown),
        .o_hit    (hit),
        .o_view   (view)
    );

    always_comb begin
        load      = (r_mode == M_VIEW) || (r_mode >= M_ALM0);
        n_hour    = load ? i_word.rtc_hour   : r_hour;
        n_min     = load ? i_word.rtc_minute : r_min;
        n_sec     = load ? i_word.rtc_second : r_sec;
        n_mode    = r_mode;
        n_sel     = r_sel;
        n_fld     = r_fld;
        ring_kept = r_ring;
        store     = 1'b0;
        up        = (i_word.cmd == CMD_ADD);
        edit      = '0;

        case (i_word.cmd)
            CMD_OK: begin
                ring_kept = 1'b0;
                if (r_mode != M_VIEW) begin
                    n_mode = M_VIEW;
                    store  = 1'b1;
                end
            end
            CMD_MODE: begin
                if ((r_mode == M_VIEW) || (r_mode == M_LAST)) begin
                    n_mode = M_HOUR;
                end else begin
                    n_mode = r_mode + 1'b1;
                    if (r_mode == M_SEC) begin
                        store = 1'b1;
                        n_sel = '0;
                        n_fld = FLD_HOUR;
                    end else if (r_mode >= M_ALM0) begin
                        if (r_fld == FLD_EN) begin
                            n_fld = FLD_HOUR;
                            n_sel = r_sel + 1'b1;
                        end else begin
                            n_fld = r_fld + 2'd1;
                        end
                    end
                end
            end
            CMD_ADD, CMD_MINUS: begin
                if (r_mode == M_HOUR) begin
                    n_hour = 5'(wrap_step({1'b0, n_hour}, HOUR_LIM, up));
                end else if (r_mode == M_MIN) begin
                    n_min = wrap_step(n_min, MIN_LIM, up);
                end else if (r_mode == M_SEC) begin
                    n_sec = wrap_step(n_sec, MIN_LIM, up);
                end else if (r_mode >= M_ALM0) begin
                    edit.adj = 1'b1;
                    edit.up  = up;
                    edit.fld = r_fld;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        // ring once per hour:minute
        n_ring    = ring_kept;
        n_lm_vld  = r_lm_vld;
        n_lm_hour = r_lm_hour;
        n_lm_min  = r_lm_min;
        if (!n_ring && hit &&
            !(r_lm_vld && (r_lm_hour == n_hour) && (r_lm_min == n_min))) begin
            n_ring    = 1'b1;
            n_lm_vld  = 1'b1;
            n_lm_hour = n_hour;
            n_lm_min  = n_min;
        end

        idx_inc    = {1'b0, r_view_idx} + 1'b1;
        n_view_idx = r_view_idx;
        n_view_cnt = 8'd0;
        if (n_mode == M_VIEW) begin
            n_view_cnt = r_view_cnt + 8'd1;
            if (n_view_cnt >= i_view_period) begin
                n_view_cnt = 8'd0;
                n_view_idx = (idx_inc >= N_ALM) ? '0 : idx_inc[IDX_W-1:0];
            end
        end else if (n_mode >= M_ALM0) begin
            n_view_idx = n_sel;
        end

        shown = ({1'b0, n_view_idx} >= N_ALM) ? '0 : n_view_idx;
    end

    always_comb begin
        o_res.cur_hour           = n_hour;
        o_res.cur_minute         = n_min;
        o_res.cur_second         = n_sec;
        o_res.edit_state         = 4'(n_mode);
        o_res.alarm_active       = n_ring;
        o_res.rtc_store          = store;
        o_res.shown_alarm        = 2'(shown);
        o_res.shown_alarm_hour   = view.hour;
        o_res.shown_alarm_minute = view.minute;
        o_res.shown_alarm_on     = view.on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour     <= '0;
            r_min      <= '0;
            r_sec      <= '0;
            r_mode     <= M_VIEW;
            r_sel      <= '0;
            r_fld      <= FLD_HOUR;
            r_ring     <= 1'b0;
            r_lm_vld   <= 1'b0;
            r_lm_hour  <= '0;
            r_lm_min   <= '0;
            r_view_idx <= '0;
            r_view_cnt <= '0;
        end else if (i_step) begin
            r_hour     <= n_hour;
            r_min      <= n_min;
            r_sec      <= n_sec;
            r_mode     <= n_mode;
            r_sel      <= n_sel;
            r_fld      <= n_fld;
            r_ring     <= n_ring;
            r_lm_vld   <= n_lm_vld;
            r_lm_hour  <= n_lm_hour;
            r_lm_min   <= n_lm_min;
            r_view_idx <= n_view_idx;
            r_view_cnt <= n_view_cnt;
        end
    end

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= M_LAST)
        else $error("edit mode beyond last alarm field");

    a_edit_shows_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode >= M_ALM0) |-> (r_view_idx == r_sel))
        else $error("shown alarm differs from alarm under edit");

    a_store_from_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.rtc_store) |-> (r_mode != M_VIEW))
        else $error("store request raised from view mode");

    a_ring_has_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring |-> r_lm_vld)
        else $error("ringing without a recorded match");

endmodule

>>> dv/testbench.sv
module testbench;
    import acc_pkg::*;

    localparam int N_ALM = NUM_ALARMS_DEF;
    localparam int LAST_EDIT = MODE_ALM0 + 3 * N_ALM - 1;
    localparam logic [2:0] CMD_JUNK_LO = 3'd5;
    localparam logic [2:0] CMD_JUNK_HI = 3'd7;
    localparam logic [PADDR_W-1:0] PERIOD_ADDR = PADDR_W'(4 * REG_VIEW_PERIOD);
    localparam int SETTLE_CYCLES = 4;
    localparam int WORDS_PER_PHASE = 325;
    localparam int PAUSE_AT = 160;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word exp;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_word           i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_word          o_out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    alarm_clock_controller_top dut (.*);

    always #6 i_clk = ~i_clk;

    // clock model state
    logic [7:0] p_period;
    logic [4:0] p_hour;
    logic [5:0] p_min;
    logic [5:0] p_sec;
    logic [3:0] p_mode;
    logic       p_ring;
    logic [7:0] p_lm_hour;
    logic [7:0] p_lm_min;
    logic [4:0] alm_hour [N_ALM];
    logic [5:0] alm_min [N_ALM];
    logic       alm_on [N_ALM];
    logic [1:0] p_vidx;
    logic [7:0] p_vcnt;

    t_out_word expected_passes[$];
    int        in_idle_pct;
    int        out_idle_pct;
    int        errors;

    function automatic int roll(int v, int lim, bit up);
        return up ? (v + 1) % lim : (v + lim - 1) % lim;
    endfunction

    task automatic reset_clock_model();
        p_period = VIEW_PERIOD_RST;
        p_hour = '0;
        p_min = '0;
        p_sec = '0;
        p_mode = '0;
        p_ring = 1'b0;
        p_lm_hour = 8'hff;
        p_lm_min = 8'hff;
        for (int i = 0; i < N_ALM; i++) begin
            alm_hour[i] = (i == 0) ? 5'd7 : (i == 1) ? 5'd12 : (i == 2) ? 5'd18 : 5'd0;
            alm_min[i] = '0;
            alm_on[i] = (i == 0);
        end
        p_vidx = '0;
        p_vcnt = '0;
    endtask

    task automatic advance_clock(input t_in_word w, output t_out_word r);
        bit up;
        bit found;
        bit store;
        int a;
        int f;
        int i;
        int shown;
        store = 1'b0;
        up = (w.cmd == CMD_ADD);
        if (p_mode == MODE_VIEW || p_mode >= MODE_ALM0) begin
            p_hour = w.rtc_hour;
            p_min = w.rtc_minute;
            p_sec = w.rtc_second;
        end
        case (w.cmd)
            CMD_OK: begin
                p_ring = 1'b0;
                if (p_mode != MODE_VIEW) begin
                    p_mode = MODE_VIEW;
                    store = 1'b1;
                end
            end
            CMD_MODE: begin
                if (p_mode == MODE_VIEW) begin
                    p_mode = MODE_HOUR;
                end else begin
                    if (p_mode == MODE_SEC) begin
                        store = 1'b1;
                    end
                    p_mode = (p_mode == LAST_EDIT) ? 4'(MODE_HOUR) : 4'(p_mode + 1);
                end
            end
            CMD_ADD, CMD_MINUS: begin
                if (p_mode == MODE_HOUR) begin
                    p_hour = 5'(roll(int'(p_hour), int'(HOUR_LIM), up));
                end else if (p_mode == MODE_MIN) begin
                    p_min = 6'(roll(int'(p_min), int'(MIN_LIM), up));
                end else if (p_mode == MODE_SEC) begin
                    p_sec = 6'(roll(int'(p_sec), int'(MIN_LIM), up));
                end else if (p_mode >= MODE_ALM0) begin
                    a = (p_mode - MODE_ALM0) / 3;
                    f = (p_mode - MODE_ALM0) % 3;
                    if (f == FLD_HOUR) begin
                        alm_hour[a] = 5'(roll(int'(alm_hour[a]), int'(HOUR_LIM), up));
                    end else if (f == FLD_MIN) begin
                        alm_min[a] = 6'(roll(int'(alm_min[a]), int'(MIN_LIM), up));
                    end else begin
                        alm_on[a] = !alm_on[a];
                    end
                end
            end
            default: ;
        endcase

        // rings at most once per hour:minute
        if (!p_ring && !(p_lm_hour == p_hour && p_lm_min == p_min)) begin
            found = 1'b0;
            for (i = 0; i < N_ALM; i++) begin
                if (!found && alm_on[i] && alm_hour[i] == p_hour && alm_min[i] == p_min) begin
                    found = 1'b1;
                    p_ring = 1'b1;
                    p_lm_hour = 8'(p_hour);
                    p_lm_min = 8'(p_min);
                end
            end
        end

        if (p_mode == MODE_VIEW) begin
            p_vcnt = 8'(p_vcnt + 1);
            if (p_vcnt >= p_period) begin
                p_vcnt = '0;
                p_vidx = (p_vidx + 1 >= N_ALM) ? 2'd0 : 2'(p_vidx + 1);
            end
        end else if (p_mode >= MODE_ALM0) begin
            p_vidx = 2'((p_mode - MODE_ALM0) / 3);
            p_vcnt = '0;
        end else begin
            p_vcnt = '0;
        end

        shown = (p_vidx >= N_ALM) ? 0 : int'(p_vidx);
        r.cur_hour = p_hour;
        r.cur_minute = p_min;
        r.cur_second = p_sec;
        r.edit_state = p_mode;
        r.alarm_active = p_ring;
        r.rtc_store = store;
        r.shown_alarm = 2'(shown);
        r.shown_alarm_hour = alm_hour[shown];
        r.shown_alarm_minute = alm_min[shown];
        r.shown_alarm_on = alm_on[shown];
    endtask

    task automatic cmp_field(string name, logic [7:0] e, logic [7:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
        end
    endtask

    task automatic check_pass(t_out_word e, t_out_word a);
        cmp_field("cur_hour", 8'(e.cur_hour), 8'(a.cur_hour));
        cmp_field("cur_minute", 8'(e.cur_minute), 8'(a.cur_minute));
        cmp_field("cur_second", 8'(e.cur_second), 8'(a.cur_second));
        cmp_field("edit_state", 8'(e.edit_state), 8'(a.edit_state));
        cmp_field("alarm_active", 8'(e.alarm_active), 8'(a.alarm_active));
        cmp_field("rtc_store", 8'(e.rtc_store), 8'(a.rtc_store));
        cmp_field("shown_alarm", 8'(e.shown_alarm), 8'(a.shown_alarm));
        cmp_field("shown_alarm_hour", 8'(e.shown_alarm_hour), 8'(a.shown_alarm_hour));
        cmp_field("shown_alarm_minute", 8'(e.shown_alarm_minute),
                  8'(a.shown_alarm_minute));
        cmp_field("shown_alarm_on", 8'(e.shown_alarm_on), 8'(a.shown_alarm_on));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_passes.size() == 0) begin
                errors++;
                $display("%0t: unexpected output word %h", $time, o_out_word);
            end else begin
                check_pass(expected_passes.pop_front(), o_out_word);
            end
        end
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // valid is left high after acceptance; the next call or a drain decides its level
    task automatic send_word(t_in_word w, bit typed, t_out_word exp);
        t_out_word r;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        advance_clock(w, r);
        expected_passes.push_back(typed ? exp : r);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (expected_passes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(bit wr, logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d,
                              output logic [PDATA_W-1:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (wr && a == PERIOD_ADDR) begin
            p_period = d[7:0];
        end
        @(posedge i_clk);
    endtask

    task automatic set_period(logic [7:0] v);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, PERIOD_ADDR, PDATA_W'(v), rd);
        apb_access(1'b0, PERIOD_ADDR, '0, rd);
        cmp_field("view_period", p_period, rd[7:0]);
    endtask

    function automatic t_stim_row key_row(logic [2:0] c, int h, int m, int s);
        t_stim_row r;
        r.w = '{c, 5'(h), 6'(m), 6'(s)};
        r.typed = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    function automatic t_stim_row known_row(logic [2:0] c, int h, int m, int s, t_out_word e);
        t_stim_row r;
        r = key_row(c, h, m, s);
        r.typed = 1'b1;
        r.exp = e;
        return r;
    endfunction

    task automatic next_random_word(int key_pct, output t_in_word w);
        int pick;
        int a;
        pick = $urandom_range(99);
        if ($urandom_range(99) >= key_pct) begin
            w.cmd = CMD_NONE;
        end else if (pick < 30) begin
            w.cmd = CMD_MODE;
        end else if (pick < 52) begin
            w.cmd = CMD_ADD;
        end else if (pick < 74) begin
            w.cmd = CMD_MINUS;
        end else if (pick < 90) begin
            w.cmd = CMD_OK;
        end else begin
            w.cmd = 3'($urandom_range(CMD_JUNK_HI, CMD_JUNK_LO));
        end
        // lean towards alarm times so that matches actually happen
        pick = $urandom_range(99);
        if (pick < 45) begin
            a = $urandom_range(N_ALM - 1);
            w.rtc_hour = alm_hour[a];
            w.rtc_minute = alm_min[a];
            w.rtc_second = 6'($urandom_range(59));
        end else if (pick < 90) begin
            w.rtc_hour = 5'($urandom_range(23));
            w.rtc_minute = 6'($urandom_range(59));
            w.rtc_second = 6'($urandom_range(59));
        end else begin
            w.rtc_hour = 5'($urandom);
            w.rtc_minute = 6'($urandom);
            w.rtc_second = 6'($urandom);
        end
    endtask

    initial begin
        #(12 * 500000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_stim_row rows[$];
        t_in_word  w;
        int        key_pct;
        logic [7:0] period;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        in_idle_pct = 0;
        out_idle_pct = 0;
        reset_clock_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(known_row(CMD_NONE, 0, 0, 0, '{5'd0, 6'd0, 6'd0, 4'(MODE_VIEW),
            1'b0, 1'b0, 2'd0, 5'd7, 6'd0, 1'b1}));
        rows.push_back(known_row(CMD_NONE, 7, 0, 59, '{5'd7, 6'd0, 6'd59, 4'(MODE_VIEW),
            1'b1, 1'b0, 2'd0, 5'd7, 6'd0, 1'b1}));
        // same minute again after OK must not ring
        rows.push_back(known_row(CMD_OK, 7, 0, 0, '{5'd7, 6'd0, 6'd0, 4'(MODE_VIEW),
            1'b0, 1'b0, 2'd0, 5'd7, 6'd0, 1'b1}));
        rows.push_back(known_row(CMD_JUNK_HI, 31, 63, 63, '{5'd31, 6'd63, 6'd63,
            4'(MODE_VIEW), 1'b0, 1'b0, 2'd0, 5'd7, 6'd0, 1'b1}));
        rows.push_back(key_row(CMD_ADD, 23, 59, 59));
        rows.push_back(key_row(CMD_MODE, 31, 63, 63));
        rows.push_back(key_row(CMD_ADD, 1, 1, 1));
        rows.push_back(key_row(CMD_MODE, 1, 1, 1));
        rows.push_back(key_row(CMD_ADD, 1, 1, 1));
        rows.push_back(key_row(CMD_MODE, 1, 1, 1));
        rows.push_back(key_row(CMD_MINUS, 1, 1, 1));
        rows.push_back(key_row(CMD_MODE, 1, 1, 1));
        rows.push_back(key_row(CMD_MINUS, 6, 59, 0));
        rows.push_back(key_row(CMD_MODE, 6, 59, 0));
        rows.push_back(key_row(CMD_MINUS, 6, 59, 0));
        rows.push_back(key_row(CMD_MODE, 6, 59, 10));
        rows.push_back(key_row(CMD_ADD, 12, 0, 0));
        rows.push_back(key_row(CMD_MODE, 12, 0, 0));
        rows.push_back(key_row(CMD_MODE, 12, 0, 0));
        rows.push_back(key_row(CMD_MODE, 12, 0, 0));
        rows.push_back(key_row(CMD_ADD, 12, 0, 30));
        for (int k = 0; k < 4; k++) begin
            rows.push_back(key_row(CMD_MODE, 18, 0, k));
        end
        rows.push_back(key_row(CMD_OK, 18, 0, 5));
        rows.push_back(key_row(CMD_JUNK_LO, 0, 0, 0));
        foreach (rows[k]) begin
            send_word(rows[k].w, rows[k].typed, rows[k].exp);
        end
        wait_results_done();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct = 15;
                    out_idle_pct = 73;
                    period = 8'd1;
                    key_pct = 50;
                end
                1: begin
                    in_idle_pct = 73;
                    out_idle_pct = 15;
                    period = 8'd255;
                    key_pct = 3;
                end
                2: begin
                    in_idle_pct = 0;
                    out_idle_pct = 0;
                    period = 8'd0;
                    key_pct = 50;
                end
                default: begin
                    in_idle_pct = 0;
                    out_idle_pct = 0;
                    period = 8'($urandom_range(30, 2));
                    key_pct = 30;
                end
            endcase
            set_period(period);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n == PAUSE_AT) begin
                    wait_results_done();
                end
                next_random_word(key_pct, w);
                send_word(w, 1'b0, '0);
            end
            wait_results_done();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
